// File: src/uvsg_pkg.sv
`timescale 1ns / 1ps

package uvsg_pkg;

	typedef enum logic [7:0] {
		REG_STACK_COUNT  = 8'd0,
		REG_SLICE_COUNT  = 8'd1,
		REG_SPHERE_RADIUS = 8'd2,
		REG_FLIP_V       = 8'd3
	} cfg_reg_t;

	localparam int DIV_W      = 44;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = DIV_W / DIV_STEPS;
	localparam int DIV_LANES  = 4;

	localparam int SIN_MULS = 7;
	localparam int SIN_LAT  = 2 * SIN_MULS + 2;

	localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	localparam logic signed [32:0] SIN_SEED = -33'sd3864;
	localparam logic signed [32:0] SIN_ADD [SIN_MULS] = '{
		33'sd0,
		33'sd172272,
		-33'sd5026995,
		33'sd85569306,
		-33'sd693598669,
		33'sd1686629713,
		33'sd0
	};

	typedef struct packed {
		logic [10:0]      rem;
		logic [DIV_W-1:0] nq;
	} div_t;

	typedef struct packed {
		logic [16:0] u;
		logic [16:0] v;
	} tex_t;

	function automatic div_t div_steps(input div_t x, input logic [10:0] d);
		div_t        y;
		logic [11:0] r;
		y = x;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r = {y.rem, y.nq[DIV_W-1]};
			y.nq = {y.nq[DIV_W-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				y.nq[0] = 1'b1;
			end
			y.rem = r[10:0];
		end
		return y;
	endfunction

	// round half away from zero, then shift right
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
		input int unsigned sh);
		logic signed [63:0] h;
		logic signed [63:0] r;
		h = (sh == 0) ? 64'sd0 : (64'sd1 <<< (sh - 1));
		if (sh == 0) begin
			r = p;
		end else begin
			r = (p + h - ((p < 0) ? 64'sd1 : 64'sd0)) >>> sh;
		end
		return r;
	endfunction

endpackage

// File: src/uvsg_sine.sv
`timescale 1ns / 1ps

module uvsg_sine #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic [31:0]                   phase,
	output logic signed [TRIG_FRAC_BITS+1:0] sine
);
	import uvsg_pkg::*;

	localparam int SW = TRIG_FRAC_BITS + 2;
	localparam int SH = 30 - TRIG_FRAC_BITS;
	localparam logic [31:0] HALF = (32'd1 << SH) >> 1;

	logic signed [32:0] t_s   [2*SIN_MULS-1];
	logic               neg_s [2*SIN_MULS+1];
	logic signed [31:0] u_s   [2*SIN_MULS-6];
	logic signed [63:0] prod_s [SIN_MULS];
	logic signed [32:0] acc_s  [SIN_MULS];
	logic signed [32:0] mul_a  [SIN_MULS];
	logic signed [31:0] mul_b  [SIN_MULS];
	logic [30:0]        t_in;
	logic [30:0]        clamp;
	logic [31:0]        mag;

	assign t_in = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};

	always_comb begin
		mul_a[0] = t_s[0];
		mul_b[0] = t_s[0][31:0];
		mul_a[1] = SIN_SEED;
		mul_b[1] = acc_s[0][31:0];
		for (int j = 2; j < SIN_MULS - 1; j++) begin
			mul_a[j] = acc_s[j-1];
			mul_b[j] = u_s[2*j-3];
		end
		mul_a[SIN_MULS-1] = acc_s[SIN_MULS-2];
		mul_b[SIN_MULS-1] = t_s[2*SIN_MULS-2][31:0];
	end

	always_comb begin
		if (acc_s[SIN_MULS-1][32]) begin
			clamp = '0;
		end else if (acc_s[SIN_MULS-1] > $signed({2'b0, Q30_ONE})) begin
			clamp = Q30_ONE;
		end else begin
			clamp = acc_s[SIN_MULS-1][30:0];
		end
		mag = ({1'b0, clamp} + HALF) >> SH;
	end

	always_ff @(posedge clk) begin
		t_s[0]   <= {2'b0, t_in};
		neg_s[0] <= phase[31];
		for (int k = 1; k < 2*SIN_MULS-1; k++) begin
			t_s[k] <= t_s[k-1];
		end
		for (int k = 1; k < 2*SIN_MULS+1; k++) begin
			neg_s[k] <= neg_s[k-1];
		end
		u_s[0] <= acc_s[0][31:0];
		for (int k = 1; k < 2*SIN_MULS-6; k++) begin
			u_s[k] <= u_s[k-1];
		end
		for (int j = 0; j < SIN_MULS; j++) begin
			prod_s[j] <= mul_a[j] * mul_b[j];
			acc_s[j]  <= SIN_ADD[j] + 33'(rnd_shift(prod_s[j], 30));
		end
		sine <= neg_s[2*SIN_MULS] ? -$signed(SW'(mag)) : $signed(SW'(mag));
	end

endmodule

// File: src/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// command   in         start & !busy          stack_index, slice_index
// result    out        done, one cycle        pos_x/y/z, normal_x/y/z, tex_u, tex_v
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One vertex enters per cycle, and its result passes through these registered stages:
// 1 index saturation stage, the 11-stage long divider (4 quotient bits a stage),
// the 16-stage sine (fold, one multiply or one round-add a stage, final rounding)
// and 4 stages of normal and position products.
// Reset loads the register defaults and empties the pipeline.
// The result side cannot stall, so the pipeline always advances.

module uv_sphere_vertex_generator #(
	parameter int unsigned MAX_DIVISIONS  = 1024,
	parameter int          TRIG_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  stack_index,
	input  logic [9:0]  slice_index,
	output logic        done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0] tex_u,
	output logic [16:0] tex_v,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import uvsg_pkg::*;

	localparam int SW        = TRIG_FRAC_BITS + 2;
	localparam int OUT_STAGE = DIV_STAGES + SIN_LAT + 4;
	localparam int TEX_LEN   = OUT_STAGE - DIV_STAGES;

	logic [10:0] stack_count_q;
	logic [10:0] slice_count_q;
	logic [15:0] sphere_radius_q;
	logic        flip_v_q;

	logic [10:0] ds;
	logic [10:0] dc;
	logic [10:0] dvs [DIV_LANES];
	logic        accept;

	logic [OUT_STAGE:0] vld_s;
	logic [9:0]  row_s0;
	logic [9:0]  col_s0;
	div_t        div_init [DIV_LANES];
	div_t        div_s [DIV_STAGES][DIV_LANES];
	tex_t        tex_s [TEX_LEN];

	logic [31:0] theta;
	logic [31:0] phi;
	logic signed [SW-1:0] sphi;
	logic signed [SW-1:0] cphi;
	logic signed [SW-1:0] sth;
	logic signed [SW-1:0] cth;

	logic signed [2*SW-1:0] mx_s1;
	logic signed [2*SW-1:0] mz_s1;
	logic signed [SW-1:0]   ny_s1;
	logic signed [SW-1:0]   nx_s2;
	logic signed [SW-1:0]   ny_s2;
	logic signed [SW-1:0]   nz_s2;
	logic signed [SW+16:0]  px_s3;
	logic signed [SW+16:0]  py_s3;
	logic signed [SW+16:0]  pz_s3;
	logic signed [15:0]     qx_s3;
	logic signed [15:0]     qy_s3;
	logic signed [15:0]     qz_s3;
	logic signed [15:0]     qx;
	logic signed [15:0]     qy;
	logic signed [15:0]     qz;

	function automatic logic [10:0] count_div(input logic [10:0] c);
		logic [10:0] k;
		if (c < 11'd2) begin
			k = 11'd2;
		end else if (32'(c) > MAX_DIVISIONS) begin
			k = MAX_DIVISIONS[10:0];
		end else begin
			k = c;
		end
		return k - 11'd1;
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign ds        = count_div(stack_count_q);
	assign dc        = count_div(slice_count_q);
	assign dvs[0]    = dc;
	assign dvs[1]    = ds;
	assign dvs[2]    = dc;
	assign dvs[3]    = ds;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q   <= 11'd32;
			slice_count_q   <= 11'd32;
			sphere_radius_q <= 16'd256;
			flip_v_q        <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STACK_COUNT:   stack_count_q   <= cfg_data[10:0];
				REG_SLICE_COUNT:   slice_count_q   <= cfg_data[10:0];
				REG_SPHERE_RADIUS: sphere_radius_q <= cfg_data;
				REG_FLIP_V:        flip_v_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[OUT_STAGE-1:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		row_s0 <= ({1'b0, stack_index} > ds) ? ds[9:0] : stack_index;
		col_s0 <= ({1'b0, slice_index} > dc) ? dc[9:0] : slice_index;
	end

	always_comb begin
		div_init[0].rem = '0;
		div_init[0].nq  = {2'b0, col_s0, 32'b0} + DIV_W'(dc >> 1);
		div_init[1].rem = '0;
		div_init[1].nq  = {3'b0, row_s0, 31'b0} + DIV_W'(ds >> 1);
		div_init[2].rem = '0;
		div_init[2].nq  = {18'b0, col_s0, 16'b0} + DIV_W'(dc >> 1);
		div_init[3].rem = '0;
		div_init[3].nq  = {18'b0, row_s0, 16'b0} + DIV_W'(ds >> 1);
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < DIV_LANES; l++) begin
			div_s[0][l] <= div_steps(div_init[l], dvs[l]);
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_s[k][l] <= div_steps(div_s[k-1][l], dvs[l]);
			end
		end
	end

	assign theta = div_s[DIV_STAGES-1][0].nq[31:0];
	assign phi   = div_s[DIV_STAGES-1][1].nq[31:0];

	always_ff @(posedge clk) begin
		tex_s[0].u <= div_s[DIV_STAGES-1][2].nq[16:0];
		tex_s[0].v <= flip_v_q ? div_s[DIV_STAGES-1][3].nq[16:0]
			: 17'd65536 - div_s[DIV_STAGES-1][3].nq[16:0];
		for (int k = 1; k < TEX_LEN; k++) begin
			tex_s[k] <= tex_s[k-1];
		end
	end

	uvsg_sine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_phi (
		.clk(clk), .phase(phi), .sine(sphi)
	);
	uvsg_sine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_phi (
		.clk(clk), .phase(phi + PHASE_QUARTER), .sine(cphi)
	);
	uvsg_sine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_theta (
		.clk(clk), .phase(theta), .sine(sth)
	);
	uvsg_sine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_theta (
		.clk(clk), .phase(theta + PHASE_QUARTER), .sine(cth)
	);

	generate
		if (TRIG_FRAC_BITS >= 14) begin : g_q14_down
			assign qx = 16'(rnd_shift(64'(nx_s2), TRIG_FRAC_BITS - 14));
			assign qy = 16'(rnd_shift(64'(ny_s2), TRIG_FRAC_BITS - 14));
			assign qz = 16'(rnd_shift(64'(nz_s2), TRIG_FRAC_BITS - 14));
		end else begin : g_q14_up
			assign qx = 16'(64'(nx_s2) <<< (14 - TRIG_FRAC_BITS));
			assign qy = 16'(64'(ny_s2) <<< (14 - TRIG_FRAC_BITS));
			assign qz = 16'(64'(nz_s2) <<< (14 - TRIG_FRAC_BITS));
		end
	endgenerate

	always_ff @(posedge clk) begin
		mx_s1 <= sphi * sth;
		mz_s1 <= sphi * cth;
		ny_s1 <= cphi;

		nx_s2 <= SW'(rnd_shift(64'(mx_s1), TRIG_FRAC_BITS));
		ny_s2 <= ny_s1;
		nz_s2 <= SW'(rnd_shift(64'(mz_s1), TRIG_FRAC_BITS));

		px_s3 <= $signed({1'b0, sphere_radius_q}) * nx_s2;
		py_s3 <= $signed({1'b0, sphere_radius_q}) * ny_s2;
		pz_s3 <= $signed({1'b0, sphere_radius_q}) * nz_s2;
		qx_s3 <= qx;
		qy_s3 <= qy;
		qz_s3 <= qz;

		pos_x    <= 17'(rnd_shift(64'(px_s3), TRIG_FRAC_BITS));
		pos_y    <= 17'(rnd_shift(64'(py_s3), TRIG_FRAC_BITS));
		pos_z    <= 17'(rnd_shift(64'(pz_s3), TRIG_FRAC_BITS));
		normal_x <= qx_s3;
		normal_y <= qy_s3;
		normal_z <= qz_s3;
	end

	assign tex_u = tex_s[TEX_LEN-1].u;
	assign tex_v = tex_s[TEX_LEN-1].v;
	assign done  = vld_s[OUT_STAGE];

endmodule

// File: src/uvsg_check.sv
`timescale 1ns / 1ps

module uvsg_check (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic signed [15:0] normal_y,
	input logic [16:0] tex_u,
	input logic [16:0] tex_v
);

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##32 done)
		else $error("accepted word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, 32))
		else $error("result without accepted word");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tex_u <= 17'd65536 && tex_v <= 17'd65536))
		else $error("texture coordinate out of range");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_y <= 16'sd16384 && normal_y >= -16'sd16384))
		else $error("normal out of range");

endmodule

bind uv_sphere_vertex_generator uvsg_check u_check (.*);
